>>> rtl/dra_pkg.sv
// Shared types and constants for the dyadic rational ALU.
`default_nettype none

package dra_pkg;

    localparam int NW      = 32;          // numerator width
    localparam int EW      = 6;           // exponent field width
    localparam int EXP_MAX = 63;          // largest legal exponent, EXP_MAX + 1 == 2**EW

    localparam int OPW = NW + 1;          // exact negation of a numerator
    localparam int SHW = OPW + EXP_MAX;   // aligned operand
    localparam int VW  = SHW + 1;         // sum of two aligned operands, holds a product too
    localparam int VEW = EW + 1;          // exponent of a product

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_SUB  = 3'd1,
        K_MUL  = 3'd2,
        K_NEG  = 3'd3,
        K_CMP  = 3'd4,
        K_NORM = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [NW-1:0] a_num;
        logic [EW-1:0]        a_exp;
        logic signed [NW-1:0] b_num;
        logic [EW-1:0]        b_exp;
    } t_op;

    typedef struct packed {
        logic signed [NW-1:0] res_num;
        logic [EW-1:0]        res_exp;
        logic                 less;
        logic                 equal;
        logic                 overflow;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/dra_norm.sv
// Partial normalizer: strips trailing zero bits in power-of-two steps, largest step first.
`default_nettype none

module dra_norm
    import dra_pkg::*;
#(
    parameter int W   = 32,
    parameter int EXW = 6,
    parameter int TOP = 5,   // log2 of the first step
    parameter int CNT = 3    // number of steps, down to 2**(TOP-CNT+1)
) (
    input  logic signed [W-1:0]   i_num,
    input  logic        [EXW-1:0] i_exp,
    output logic signed [W-1:0]   o_num,
    output logic        [EXW-1:0] o_exp
);

    // Greedy steps give min(trailing zeros, exponent) once all steps down to 1 have run;
    // a zero numerator counts as all-zero and drains the exponent.
    always_comb begin : p_norm
        logic signed [W-1:0] v;
        logic [EXW-1:0]      e;
        int                  step;
        v = i_num;
        e = i_exp;
        for (int k = 0; k < CNT; k++) begin
            step = 1 << (TOP - k);
            if (((v & ~({W{1'b1}} << step)) == '0) && (int'(e) >= step)) begin
                v = v >>> step;
                e = e - EXW'(step);
            end
        end
        o_num = v;
        o_exp = e;
    end

endmodule

`default_nettype wire

>>> rtl/dyadic_rational_alu.sv
// Top level: seven-stage pipelined ALU on dyadic fractions num / 2^exp.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------
//   op      | in        | i_op_valid / o_op_ready    | i_op  (kind, a/b num and exp)
//   res     | out       | o_res_valid / i_res_ready  | o_res (num, exp, less, equal, ovf)
//
// One item per cycle sustained while i_res_ready stays high.
// Stages: operand normalize (2), align shift and multiply, add/compare,
// result normalize (2), overflow check into the output register.
// Each stage holds its item while the next one is full and stalled, so empty
// stages keep filling while a result waits. Reset clears only the valid bits.
`default_nettype none

module dyadic_rational_alu
    import dra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_valid,
    output logic o_op_ready,
    input  t_op  i_op,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int NST = 7;

    logic [NST-1:0] r_valid;
    logic [NST-1:0] w_en;

    // per-stage load enables, a stage loads when empty or when the next one loads
    always_comb begin
        w_en[NST-1] = !r_valid[NST-1] || i_res_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_op_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_op_ready  = w_en[0] && i_rst_n;
    assign o_res_valid = r_valid[NST-1];

    // ---------------- stage 1: operand normalize, coarse steps
    logic signed [NW-1:0] n1_a, n1_b;
    logic [EW-1:0]        n1_ea, n1_eb;
    logic [2:0]           r1_kind;
    logic signed [NW-1:0] r1_a, r1_b;
    logic [EW-1:0]        r1_ea, r1_eb;

    dra_norm #(.W(NW), .EXW(EW), .TOP(EW - 1), .CNT(EW - 3)) u_norm_a1 (
        .i_num(i_op.a_num), .i_exp(i_op.a_exp), .o_num(n1_a), .o_exp(n1_ea)
    );
    dra_norm #(.W(NW), .EXW(EW), .TOP(EW - 1), .CNT(EW - 3)) u_norm_b1 (
        .i_num(i_op.b_num), .i_exp(i_op.b_exp), .o_num(n1_b), .o_exp(n1_eb)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_kind <= i_op.kind;
            r1_a    <= n1_a;
            r1_ea   <= n1_ea;
            r1_b    <= n1_b;
            r1_eb   <= n1_eb;
        end
    end

    // ---------------- stage 2: operand normalize, fine steps
    logic signed [NW-1:0] n2_a, n2_b;
    logic [EW-1:0]        n2_ea, n2_eb;
    logic [2:0]           r2_kind;
    logic signed [NW-1:0] r2_a, r2_b;
    logic [EW-1:0]        r2_ea, r2_eb;

    dra_norm #(.W(NW), .EXW(EW), .TOP(2), .CNT(3)) u_norm_a2 (
        .i_num(r1_a), .i_exp(r1_ea), .o_num(n2_a), .o_exp(n2_ea)
    );
    dra_norm #(.W(NW), .EXW(EW), .TOP(2), .CNT(3)) u_norm_b2 (
        .i_num(r1_b), .i_exp(r1_eb), .o_num(n2_b), .o_exp(n2_eb)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_kind <= r1_kind;
            r2_a    <= n2_a;
            r2_ea   <= n2_ea;
            r2_b    <= n2_b;
            r2_eb   <= n2_eb;
        end
    end

    // ---------------- stage 3: align the operand with the smaller exponent, multiply
    logic                   w3_ge;
    logic [EW-1:0]          w3_d;
    logic signed [SHW-1:0]  w3_a_ext, w3_b_ext, w3_sh;
    logic signed [SHW-1:0]  n3_lhs, n3_rhs;
    logic                   n3_sub;
    logic [VEW-1:0]         n3_e;
    logic signed [2*NW-1:0] n3_prod;

    logic [2:0]             r3_kind;
    logic signed [SHW-1:0]  r3_lhs, r3_rhs;
    logic                   r3_sub;
    logic [VEW-1:0]         r3_e;
    logic signed [2*NW-1:0] r3_prod;

    always_comb begin
        w3_ge    = r2_ea >= r2_eb;
        w3_d     = w3_ge ? (r2_ea - r2_eb) : (r2_eb - r2_ea);
        w3_a_ext = {{(SHW - NW){r2_a[NW-1]}}, r2_a};
        w3_b_ext = {{(SHW - NW){r2_b[NW-1]}}, r2_b};
        w3_sh    = (w3_ge ? w3_b_ext : w3_a_ext) << w3_d;
        n3_prod  = r2_a * r2_b;
        n3_lhs   = '0;
        n3_rhs   = '0;
        n3_sub   = 1'b0;
        n3_e     = '0;
        unique case (r2_kind)
            K_ADD, K_SUB, K_CMP: begin
                n3_lhs = w3_ge ? w3_a_ext : w3_sh;
                n3_rhs = w3_ge ? w3_sh : w3_b_ext;
                n3_sub = (r2_kind == K_SUB);
                n3_e   = VEW'(w3_ge ? r2_ea : r2_eb);
            end
            K_MUL: begin
                n3_e = VEW'(r2_ea) + VEW'(r2_eb);
            end
            K_NEG: begin
                // 0 - a through the shared adder
                n3_rhs = w3_a_ext;
                n3_sub = 1'b1;
                n3_e   = VEW'(r2_ea);
            end
            K_NORM: begin
                n3_lhs = w3_a_ext;
                n3_e   = VEW'(r2_ea);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_kind <= r2_kind;
            r3_lhs  <= n3_lhs;
            r3_rhs  <= n3_rhs;
            r3_sub  <= n3_sub;
            r3_e    <= n3_e;
            r3_prod <= n3_prod;
        end
    end

    // ---------------- stage 4: add or subtract, compare
    logic signed [VW-1:0] w4_lhs, w4_rhs, w4_sum;
    logic signed [VW-1:0] n4_v;
    logic                 n4_less, n4_equal;

    logic [2:0]           r4_kind;
    logic signed [VW-1:0] r4_v;
    logic [VEW-1:0]       r4_e;
    logic                 r4_less, r4_equal;

    always_comb begin
        w4_lhs   = {r3_lhs[SHW-1], r3_lhs};
        w4_rhs   = {r3_rhs[SHW-1], r3_rhs};
        w4_sum   = w4_lhs + (r3_sub ? ~w4_rhs : w4_rhs) + VW'(r3_sub);
        n4_less  = r3_lhs < r3_rhs;
        n4_equal = r3_lhs == r3_rhs;
        n4_v     = (r3_kind == K_MUL) ? {{(VW - 2*NW){r3_prod[2*NW-1]}}, r3_prod} : w4_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_kind  <= r3_kind;
            r4_v     <= n4_v;
            r4_e     <= r3_e;
            r4_less  <= n4_less;
            r4_equal <= n4_equal;
        end
    end

    // ---------------- stages 5 and 6: result normalize
    logic signed [VW-1:0] n5_v, n6_v;
    logic [VEW-1:0]       n5_e, n6_e;

    logic [2:0]           r5_kind, r6_kind;
    logic signed [VW-1:0] r5_v, r6_v;
    logic [VEW-1:0]       r5_e, r6_e;
    logic                 r5_less, r5_equal, r6_less, r6_equal;

    dra_norm #(.W(VW), .EXW(VEW), .TOP(VEW - 1), .CNT(VEW - 4)) u_norm_v1 (
        .i_num(r4_v), .i_exp(r4_e), .o_num(n5_v), .o_exp(n5_e)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_kind  <= r4_kind;
            r5_v     <= n5_v;
            r5_e     <= n5_e;
            r5_less  <= r4_less;
            r5_equal <= r4_equal;
        end
    end

    dra_norm #(.W(VW), .EXW(VEW), .TOP(3), .CNT(4)) u_norm_v2 (
        .i_num(r5_v), .i_exp(r5_e), .o_num(n6_v), .o_exp(n6_e)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_kind  <= r5_kind;
            r6_v     <= n6_v;
            r6_e     <= n6_e;
            r6_less  <= r5_less;
            r6_equal <= r5_equal;
        end
    end

    // ---------------- stage 7: range check, output register
    t_res n7_res;
    t_res r7_res;
    logic w7_fits;

    always_comb begin
        w7_fits = (&r6_v[VW-1:NW-1]) || !(|r6_v[VW-1:NW-1]);
        n7_res  = '0;
        unique case (r6_kind)
            K_ADD, K_SUB, K_MUL, K_NEG, K_NORM: begin
                n7_res.res_num  = r6_v[NW-1:0];
                // exponent wraps modulo EXP_MAX + 1, a power of two
                n7_res.res_exp  = r6_e[EW-1:0];
                n7_res.overflow = !w7_fits || (r6_e > VEW'(EXP_MAX));
            end
            K_CMP: begin
                n7_res.less  = r6_less;
                n7_res.equal = r6_equal;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_res <= n7_res;
        end
    end

    assign o_res = r7_res;

    // ---------------- checks
    logic w_in_acc, w_out_acc;
    assign w_in_acc  = i_op_valid && o_op_ready;
    assign w_out_acc = o_res_valid && i_res_ready;

    // items in flight change only by the handshakes
    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_valid) == $countones($past(r_valid))
                + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("pipeline lost or duplicated an item");

    // an in-range result with a nonzero exponent has an odd numerator
    a_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.overflow && (o_res.res_exp != '0)) |-> o_res.res_num[0])
        else $error("result not normalized");

    // compare flags never come with a numeric result
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.less || o_res.equal)) |->
            (!(o_res.less && o_res.equal) && (o_res.res_num == '0)
             && (o_res.res_exp == '0) && !o_res.overflow))
        else $error("compare result carries numeric fields");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the dyadic rational ALU: predicted results compared per item.
`default_nettype none

module tb;
    import dra_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  K_RSVD6     = 3'd6;
    localparam logic [2:0]  K_RSVD7     = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PIPE_DEPTH  = 7;
    localparam int          GAP_MAX     = 16;
    localparam int          SHOW_MAX    = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_op_valid;
    logic o_op_ready;
    t_op  i_op;
    logic o_res_valid;
    logic i_res_ready;
    t_res o_res;

    t_res expected_q[$];
    int   mismatch_cnt;
    int   send_gap_max;
    int   recv_gap_max;
    int   res_hold_cycles;

    dyadic_rational_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (i_op_valid),
        .o_op_ready  (o_op_ready),
        .i_op        (i_op),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // number of trailing zero bits that normalization strips, bounded by the exponent
    function automatic int strip_count(input logic signed [127:0] v, input int e);
        int n;
        n = 0;
        while (n < e && n < 128 && !v[n]) n++;
        return n;
    endfunction

    function automatic t_res settle_result(input logic signed [127:0] v0, input int e0);
        logic signed [127:0] v;
        int                  e;
        int                  n;
        t_res                r;
        n = strip_count(v0, e0);
        v = v0 >>> n;
        e = e0 - n;
        r = '0;
        r.res_num  = v[NW-1:0];
        r.res_exp  = e[EW-1:0];
        r.overflow = (v != {{(128-NW){v[NW-1]}}, v[NW-1:0]}) || (e > EXP_MAX);
        return r;
    endfunction

    function automatic t_res dyadic_eval(input t_op op);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] x;
        logic signed [127:0] y;
        int                  ea;
        int                  eb;
        int                  n;
        t_res                r;
        a  = {{(128-NW){op.a_num[NW-1]}}, op.a_num};
        b  = {{(128-NW){op.b_num[NW-1]}}, op.b_num};
        ea = int'(op.a_exp);
        eb = int'(op.b_exp);
        n  = strip_count(a, ea);
        a  = a >>> n;
        ea = ea - n;
        n  = strip_count(b, eb);
        b  = b >>> n;
        eb = eb - n;
        r  = '0;
        case (op.kind)
            K_ADD, K_SUB: begin
                if (op.kind == K_SUB) b = -b;
                // align the operand with the smaller exponent
                if (ea >= eb) r = settle_result(a + (b <<< (ea - eb)), ea);
                else          r = settle_result(b + (a <<< (eb - ea)), eb);
            end
            K_MUL:  r = settle_result(a * b, ea + eb);
            K_NEG:  r = settle_result(-a, ea);
            K_CMP: begin
                x       = a <<< eb;
                y       = b <<< ea;
                r.less  = (x < y);
                r.equal = (x == y);
            end
            K_NORM: r = settle_result(a, ea);
            default: r = '0;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_result(input t_res got);
        t_res want;
        if (expected_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_MAX)
                $display("unexpected result item: num=%h exp=%0d lt=%b eq=%b ovf=%b",
                         got.res_num, got.res_exp, got.less, got.equal, got.overflow);
        end else begin
            want = expected_q.pop_front();
            if (got.res_num !== want.res_num || got.res_exp !== want.res_exp ||
                got.less !== want.less || got.equal !== want.equal ||
                got.overflow !== want.overflow) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOW_MAX) begin
                    $display("mismatch: exp num=%h exp=%0d lt=%b eq=%b ovf=%b",
                             want.res_num, want.res_exp, want.less, want.equal,
                             want.overflow);
                    $display("          got num=%h exp=%0d lt=%b eq=%b ovf=%b",
                             got.res_num, got.res_exp, got.less, got.equal,
                             got.overflow);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_op_valid && o_op_ready) expected_q.push_back(dyadic_eval(i_op));
            if (o_res_valid && i_res_ready) check_result(o_res);
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic int draw_gap(input int max_gap);
        if (max_gap == 0 || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(0, max_gap);
    endfunction

    // result side: random stalls, plus one long hold-off when a test asks for it
    initial begin
        int gap;
        i_res_ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (res_hold_cycles > 0) begin
                i_res_ready <= 1'b0;
                repeat (res_hold_cycles) @(posedge i_clk);
                res_hold_cycles = 0;
            end else begin
                gap = draw_gap(recv_gap_max);
                if (gap > 0) begin
                    i_res_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_res_ready <= 1'b1;
            do @(posedge i_clk); while (!o_res_valid);
        end
    end

    // valid stays high across back-to-back items, so it is only lowered for a gap
    task automatic send_op(input t_op op);
        int gap;
        gap = draw_gap(send_gap_max);
        if (gap > 0) begin
            i_op_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op_valid <= 1'b1;
        i_op       <= op;
        do @(posedge i_clk); while (!o_op_ready);
    endtask

    task automatic wait_results_done();
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    function automatic t_op make_op(input logic [2:0] kind, input logic [31:0] an,
                                    input int ae, input logic [31:0] bn, input int be);
        t_op op;
        op.kind  = kind;
        op.a_num = an;
        op.a_exp = ae[EW-1:0];
        op.b_num = bn;
        op.b_exp = be[EW-1:0];
        return op;
    endfunction

    function automatic logic [31:0] random_num();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = $urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF;
            2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: v = $urandom_range(0, 255) - 128;
            4: v = $urandom << $urandom_range(1, 31);      // many trailing zeros
            5: begin
                v = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int random_exp();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return EXP_MAX;
            2:       return $urandom_range(0, 8);
            default: return $urandom_range(0, EXP_MAX);
        endcase
    endfunction

    function automatic t_op random_op();
        logic [2:0] kind;
        if ($urandom_range(0, 15) == 0) kind = 3'($urandom_range(6, 7));
        else                            kind = 3'($urandom_range(0, 5));
        return make_op(kind, random_num(), random_exp(), random_num(), random_exp());
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
        send_op(make_op(K_ADD,  32'h1,         0,  32'h1,         0));
        send_op(make_op(K_ADD,  32'h7FFF_FFFF, 0,  32'h7FFF_FFFF, 0));
        send_op(make_op(K_ADD,  32'h8000_0000, 0,  32'h8000_0000, 0));
        send_op(make_op(K_ADD,  32'h1,         0,  32'h1,         EXP_MAX));
        // negating the most negative numerator
        send_op(make_op(K_SUB,  32'h0,         0,  32'h8000_0000, 0));
        send_op(make_op(K_SUB,  32'h8000_0000, 1,  32'h8000_0000, 1));
        send_op(make_op(K_SUB,  32'h7FFF_FFFF, 0,  32'hFFFF_FFFF, 0));
        send_op(make_op(K_MUL,  32'h7FFF_FFFF, 0,  32'h7FFF_FFFF, 0));
        send_op(make_op(K_MUL,  32'h8000_0000, 0,  32'h8000_0000, 0));
        // exponent sum past its range wraps
        send_op(make_op(K_MUL,  32'h3,         EXP_MAX, 32'h5,    EXP_MAX));
        send_op(make_op(K_MUL,  32'hFFFF_FFFF, 0,  32'h8000_0000, 0));
        send_op(make_op(K_MUL,  32'h0,         EXP_MAX, 32'h1234_5677, 7));
        send_op(make_op(K_NEG,  32'h8000_0000, 0,  32'h0,         0));
        send_op(make_op(K_NEG,  32'h8000_0000, EXP_MAX, 32'h0,    0));
        send_op(make_op(K_NEG,  32'h0,         EXP_MAX, 32'h0,    EXP_MAX));
        // equal values in different representations
        send_op(make_op(K_CMP,  32'h2,         1,  32'h1,         0));
        send_op(make_op(K_CMP,  32'hFFFF_FFFF, 0,  32'h0,         0));
        send_op(make_op(K_CMP,  32'h8000_0000, 0,  32'h7FFF_FFFF, EXP_MAX));
        send_op(make_op(K_CMP,  32'h7FFF_FFFF, 0,  32'h8000_0000, EXP_MAX));
        send_op(make_op(K_NORM, 32'h0,         EXP_MAX, 32'h7FFF_FFFF, 0));
        send_op(make_op(K_NORM, 32'h7FFF_FFFF, EXP_MAX, 32'h0,    0));
        send_op(make_op(K_NORM, 32'hFFFF_FFF8, 5,  32'h8000_0000, EXP_MAX));
        send_op(make_op(K_RSVD6, 32'h1234_5678, 9, 32'hDEAD_BEEF, 3));
        send_op(make_op(K_RSVD7, 32'h7FFF_FFFF, EXP_MAX, 32'h8000_0000, EXP_MAX));
    endtask

    task automatic test_random_mix(input int count);
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
        repeat (count) send_op(random_op());
    endtask

    task automatic test_full_rate(input int count);
        send_gap_max = 0;
        recv_gap_max = 0;
        repeat (count) send_op(random_op());
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        send_gap_max    = 0;
        recv_gap_max    = GAP_MAX;
        res_hold_cycles = 300;
        repeat (60) send_op(random_op());
        i_op_valid <= 1'b0;
        wait_results_done();
        send_gap_max = GAP_MAX;
        repeat (40) send_op(random_op());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_op_valid      = 1'b0;
        i_op            = '0;
        mismatch_cnt    = 0;
        send_gap_max    = 0;
        recv_gap_max    = 0;
        res_hold_cycles = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(600);
        test_full_rate(300);
        test_backpressure();
        test_random_mix(450);

        i_op_valid <= 1'b0;
        wait_results_done();
        repeat (3 * PIPE_DEPTH) @(posedge i_clk);
        if (expected_q.size() != 0) mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> dyadic_rational_alu.f
rtl/dra_pkg.sv
rtl/dra_norm.sv
rtl/dyadic_rational_alu.sv
sim/tb.sv
